// ===== hdl/prd_pkg.sv =====
`default_nettype none
package prd_pkg;

  localparam int MAX_BLOCK_SAMPLES = 4096;
  localparam int ORDER_FIELD_BITS  = 10;
  localparam int PARAM_FIELD_BITS  = 5;
  localparam int MAX_PART_ORDER    = 10;
  localparam int LEN_W             = 13;
  localparam int VAL_W             = 32;

  typedef enum logic [2:0] {
    PH_TYPE  = 3'd0,
    PH_ORDER = 3'd1,
    PH_PARAM = 3'd2,
    PH_DELTA = 3'd3,
    PH_QUOT  = 3'd4,
    PH_REM   = 3'd5
  } phase_t;

  localparam logic [1:0] KIND_RICE      = 2'd0;
  localparam logic [1:0] KIND_RECURSIVE = 2'd1;
  localparam logic [1:0] KIND_ALLZERO   = 2'd2;
  localparam logic [1:0] KIND_INVALID   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_TYPE  = 2'd1;
  localparam logic [1:0] ST_BAD_ORDER = 2'd2;

  typedef struct packed {
    logic signed [VAL_W-1:0] sample_value;
    logic [LEN_W-1:0]        repeat_count;
    logic                    last_in_block;
    logic [1:0]              status;
  } res_t;

  // trailing zero count of a non-zero length, capped
  function automatic logic [3:0] max_order(input logic [LEN_W-1:0] len);
    logic [3:0] o;
    logic       hit;
    o   = 4'(MAX_PART_ORDER);
    hit = 1'b0;
    for (int i = 0; i < MAX_PART_ORDER; i++) begin
      if (!hit && len[i]) begin
        o   = 4'(i);
        hit = 1'b1;
      end
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/prd_ctrl.sv =====
`default_nettype none
module prd_ctrl #(
  parameter int MAX_BLOCK_SAMPLES = prd_pkg::MAX_BLOCK_SAMPLES,
  parameter int ORDER_FIELD_BITS  = prd_pkg::ORDER_FIELD_BITS,
  parameter int PARAM_FIELD_BITS  = prd_pkg::PARAM_FIELD_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic                       bit_in,
  input  wire logic [prd_pkg::LEN_W-1:0]  block_samples,
  output prd_pkg::res_t                   res,
  output logic                            res_valid
);

  prd_pkg::phase_t             phase_r, phase_nxt;
  logic [1:0]                  kind_r, kind_nxt;
  logic [5:0]                  cnt_r, cnt_nxt;
  logic [31:0]                 acc_r, acc_nxt;
  logic [31:0]                 zrc_r, zrc_nxt;
  logic [31:0]                 qs_r, qs_nxt;
  logic [3:0]                  order_r, order_nxt;
  logic [4:0]                  rice_r, rice_nxt;
  logic [prd_pkg::LEN_W-1:0]   slp_r, slp_nxt;
  logic [prd_pkg::LEN_W-1:0]   slb_r, slb_nxt;

  logic [prd_pkg::LEN_W-1:0]   eff_len;
  logic [prd_pkg::LEN_W-1:0]   part_len;
  logic [prd_pkg::LEN_W-1:0]   slb_dec, slp_dec;
  logic [31:0]                 acc_sh;
  logic [5:0]                  cnt_inc;
  logic                        recur;
  logic [31:0]                 q_low;
  logic [5:0]                  rem_bits;
  logic [30:0]                 half;
  logic [5:0]                  dsum, dneg;
  logic [4:0]                  new_k;
  logic                        fin;
  logic [31:0]                 fin_u;

  always_comb begin
    eff_len = block_samples;
    if (eff_len == '0) eff_len = prd_pkg::LEN_W'(1);
    if (32'(block_samples) > 32'(MAX_BLOCK_SAMPLES)) eff_len = prd_pkg::LEN_W'(MAX_BLOCK_SAMPLES);
    part_len = eff_len >> order_r;
    if (part_len == '0) part_len = prd_pkg::LEN_W'(1);
  end

  assign acc_sh   = {acc_r[30:0], bit_in};
  assign cnt_inc  = cnt_r + 6'd1;
  assign recur    = (kind_r == prd_pkg::KIND_RECURSIVE);
  assign q_low    = zrc_r + 32'(recur && (zrc_r != '0));
  assign rem_bits = 6'(rice_r) + 6'(recur && (zrc_r == '0));
  assign slb_dec  = (slb_r != '0) ? slb_r - 1'b1 : slb_r;
  assign slp_dec  = (slp_r != '0) ? slp_r - 1'b1 : slp_r;

  // zigzag delta on the parameter, saturated to 0..31
  always_comb begin
    half = zrc_r[31:1];
    dsum = 6'(rice_r) + 6'(half[4:0]);
    dneg = 6'(half[4:0]) + 6'd1;
    if (half > 31'd31) begin
      new_k = zrc_r[0] ? 5'd0 : 5'd31;
    end else if (zrc_r[0]) begin
      new_k = (dneg > 6'(rice_r)) ? 5'd0 : rice_r - dneg[4:0];
    end else begin
      new_k = (dsum > 6'd31) ? 5'd31 : dsum[4:0];
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    zrc_nxt   = zrc_r;
    qs_nxt    = qs_r;
    order_nxt = order_r;
    rice_nxt  = rice_r;
    slp_nxt   = slp_r;
    slb_nxt   = slb_r;
    fin       = 1'b0;
    fin_u     = '0;
    res_valid = 1'b0;
    res       = '{sample_value: '0, repeat_count: prd_pkg::LEN_W'(1),
                  last_in_block: 1'b1, status: prd_pkg::ST_OK};

    unique case (phase_r)
      prd_pkg::PH_DELTA, prd_pkg::PH_QUOT: begin
        if (!bit_in) begin
          if (zrc_r != '1) zrc_nxt = zrc_r + 32'd1;
        end else if (phase_r == prd_pkg::PH_DELTA) begin
          rice_nxt  = new_k;
          slp_nxt   = part_len;
          phase_nxt = prd_pkg::PH_QUOT;
          zrc_nxt   = '0;
        end else begin
          acc_nxt = '0;
          cnt_nxt = '0;
          if (rem_bits == '0) begin
            fin   = 1'b1;
            fin_u = q_low;
          end else begin
            qs_nxt    = q_low << rice_r;
            phase_nxt = prd_pkg::PH_REM;
          end
        end
      end
      prd_pkg::PH_REM: begin
        acc_nxt = acc_sh;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= rem_bits) begin
          fin   = 1'b1;
          fin_u = qs_r + acc_sh;
        end
      end
      prd_pkg::PH_ORDER: begin
        acc_nxt = acc_sh;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 6'(ORDER_FIELD_BITS)) begin
          acc_nxt = '0;
          cnt_nxt = '0;
          if (acc_sh[ORDER_FIELD_BITS-1:0] >
              ORDER_FIELD_BITS'(prd_pkg::max_order(eff_len))) begin
            phase_nxt = prd_pkg::PH_TYPE;
            res_valid = 1'b1;
            res.status = prd_pkg::ST_BAD_ORDER;
          end else begin
            order_nxt = acc_sh[3:0];
            slb_nxt   = eff_len;
            phase_nxt = prd_pkg::PH_PARAM;
          end
        end
      end
      prd_pkg::PH_PARAM: begin
        acc_nxt = acc_sh;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 6'(PARAM_FIELD_BITS)) begin
          rice_nxt  = (acc_sh[PARAM_FIELD_BITS-1:0] > PARAM_FIELD_BITS'(31)) ?
                      5'd31 : acc_sh[4:0];
          slp_nxt   = part_len;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = prd_pkg::PH_QUOT;
          zrc_nxt   = '0;
        end
      end
      default: begin
        phase_nxt = prd_pkg::PH_TYPE;
        acc_nxt   = acc_sh;
        cnt_nxt   = cnt_inc;
        if (cnt_inc >= 6'd2) begin
          acc_nxt = '0;
          cnt_nxt = '0;
          unique case (acc_sh[1:0])
            prd_pkg::KIND_ALLZERO: begin
              res_valid = 1'b1;
              res.repeat_count = eff_len;
            end
            prd_pkg::KIND_INVALID: begin
              res_valid = 1'b1;
              res.status = prd_pkg::ST_BAD_TYPE;
            end
            default: begin
              kind_nxt  = acc_sh[1:0];
              phase_nxt = prd_pkg::PH_ORDER;
            end
          endcase
        end
      end
    endcase

    if (fin) begin
      res_valid = 1'b1;
      res.sample_value  = {1'b0, fin_u[31:1]} ^ {32{fin_u[0]}};
      res.last_in_block = (slb_dec == '0);
      slb_nxt = slb_dec;
      slp_nxt = slp_dec;
      acc_nxt = '0;
      cnt_nxt = '0;
      if (slb_dec == '0) begin
        phase_nxt = prd_pkg::PH_TYPE;
      end else begin
        phase_nxt = (slp_dec == '0) ? prd_pkg::PH_DELTA : prd_pkg::PH_QUOT;
        zrc_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= prd_pkg::PH_TYPE;
      kind_r  <= prd_pkg::KIND_RICE;
      cnt_r   <= '0;
      acc_r   <= '0;
      zrc_r   <= '0;
      order_r <= '0;
      rice_r  <= '0;
      slp_r   <= '0;
      slb_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      zrc_r   <= zrc_nxt;
      order_r <= order_nxt;
      rice_r  <= rice_nxt;
      slp_r   <= slp_nxt;
      slb_r   <= slb_nxt;
    end
  end

  // shifted quotient, only read in the remainder phase
  always_ff @(posedge clk) begin
    if (accept) qs_r <= qs_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/prd_outreg.sv =====
`default_nettype none
module prd_outreg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire prd_pkg::res_t  res,
  input  wire logic           res_valid,
  input  wire logic           out_tready,
  output logic                in_tready,
  output logic                out_tvalid,
  output prd_pkg::res_t       out_res
);

  logic          valid_r, valid_nxt;
  prd_pkg::res_t res_r;

  // take a new bit when no result is held, or while the held one leaves in the same cycle
  assign in_tready = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_tready) valid_nxt = 1'b0;
    if (accept && res_valid) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) res_r <= res;
  end

  assign out_tvalid = valid_r;
  assign out_res    = res_r;

endmodule
`default_nettype wire

// ===== hdl/partitioned_rice_decoder.sv =====
// A result is registered and presented in the cycle after the coded bit that completes it.
// Throughput: one coded bit per cycle, limited only by the single-stage
// state update and the one-entry result register.
// Reset: synchronous, active low; decoding restarts at a block code type
// and block_samples returns to 4096.
`default_nettype none
module partitioned_rice_decoder #(
  parameter int MAX_BLOCK_SAMPLES = prd_pkg::MAX_BLOCK_SAMPLES,
  parameter int ORDER_FIELD_BITS  = prd_pkg::ORDER_FIELD_BITS,
  parameter int PARAM_FIELD_BITS  = prd_pkg::PARAM_FIELD_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [7:0]                in_tdata,   // [0] bit_in, [7:1] zero
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [47:0]                    out_tdata,  // [31:0] sample_value,
                                                     // [44:32] repeat_count, [47:45] zero
  output logic                           out_tlast,  // last_in_block
  output logic [1:0]                     out_tuser,  // status
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [prd_pkg::LEN_W-1:0] cfg_data    // block_samples
);

  logic [prd_pkg::LEN_W-1:0] block_samples_r;
  logic                      accept;
  logic                      res_valid;
  prd_pkg::res_t             res;
  prd_pkg::res_t             out_res;

  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_samples_r <= prd_pkg::LEN_W'(4096);
    end else if (cfg_valid) begin
      block_samples_r <= cfg_data;
    end
  end

  prd_ctrl #(
    .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES),
    .ORDER_FIELD_BITS  (ORDER_FIELD_BITS),
    .PARAM_FIELD_BITS  (PARAM_FIELD_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .bit_in        (in_tdata[0]),
    .block_samples (block_samples_r),
    .res           (res),
    .res_valid     (res_valid)
  );

  prd_outreg u_outreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .res        (res),
    .res_valid  (res_valid),
    .out_tready (out_tready),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_res    (out_res)
  );

  assign out_tdata = {3'b000, out_res.repeat_count, out_res.sample_value};
  assign out_tlast = out_res.last_in_block;
  assign out_tuser = out_res.status;

endmodule
`default_nettype wire

// ===== hdl/prd_checker.sv =====
`default_nettype none
module prd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic [1:0]  out_tuser
);

  // hold a stalled transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("undefined status code");

  a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != prd_pkg::ST_OK |->
    out_tlast && out_tdata[31:0] == 32'd0 && out_tdata[44:32] == 13'd1)
    else $error("error result malformed");

  a_repeat_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[44:32] != 13'd1 |->
    out_tlast && out_tdata[31:0] == 32'd0 && out_tuser == prd_pkg::ST_OK)
    else $error("repeated result not an all-zero block");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind partitioned_rice_decoder prd_checker u_prd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire

// ===== tb/partitioned_rice_decoder_tb.sv =====
`timescale 1ns / 100ps
module partitioned_rice_decoder_tb;
  import prd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = '0;    // [0] bit_in, [7:1] zero
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [47:0]      out_tdata;          // [31:0] sample_value, [44:32] repeat_count, [47:45] zero
  logic             out_tlast;          // last_in_block
  logic [1:0]       out_tuser;          // status
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data   = '0;    // block_samples

  int send_idle_pct = 8;
  int recv_idle_pct = 77;
  int bits_sent     = 0;
  int error_count   = 0;
  int cycle_count   = 0;

  // effective block length the stimulus encodes for
  logic [LEN_W-1:0] gen_len = LEN_W'(MAX_BLOCK_SAMPLES);

  // decoder mirror, in its reset state
  phase_t           stage     = PH_TYPE;
  logic [1:0]       kind      = KIND_RICE;
  int               nbits     = 0;
  logic [31:0]      acc       = '0;
  logic [31:0]      run       = '0;
  logic [3:0]       order_q   = '0;
  logic [4:0]       kparam    = '0;
  logic [LEN_W-1:0] part_left = '0;
  logic [LEN_W-1:0] blk_left  = '0;
  logic [LEN_W-1:0] blk_reg   = LEN_W'(MAX_BLOCK_SAMPLES);

  res_t pending_results[$];

  partitioned_rice_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------- decoding mirror

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    if (v == 0) return LEN_W'(1);
    if (v > MAX_BLOCK_SAMPLES) return LEN_W'(MAX_BLOCK_SAMPLES);
    return v;
  endfunction

  // finest partition order that still tiles the block
  function automatic int order_limit(input logic [LEN_W-1:0] len);
    int o;
    o = 0;
    while (o < MAX_PART_ORDER && !len[o]) o++;
    return o;
  endfunction

  function automatic logic [LEN_W-1:0] part_length();
    logic [LEN_W-1:0] p;
    p = eff_len(blk_reg) >> order_q;
    return (p == 0) ? LEN_W'(1) : p;
  endfunction

  // zigzag run length to signed delta, sum held to 0..31
  function automatic logic [4:0] apply_delta(input logic [4:0] k, input logic [31:0] r);
    longint d;
    longint s;
    d = longint'({32'd0, r[31:1]});
    if (r[0]) d = -d - 1;
    s = longint'({59'd0, k}) + d;
    if (s < 0) s = 0;
    if (s > 31) s = 31;
    return 5'(s);
  endfunction

  function automatic int rem_width();
    return int'(kparam) + ((kind == KIND_RECURSIVE && run == 0) ? 1 : 0);
  endfunction

  function automatic res_t make_result(input logic [31:0] v, input logic [LEN_W-1:0] rep,
                                       input logic last, input logic [1:0] st);
    res_t r;
    r.sample_value  = v;
    r.repeat_count  = rep;
    r.last_in_block = last;
    r.status        = st;
    return r;
  endfunction

  task automatic close_sample();
    logic [63:0] q;
    logic [31:0] u;
    logic        last;
    q = {32'd0, run};
    if (kind == KIND_RECURSIVE && q != 0) q++;
    u = 32'((q << kparam) + {32'd0, acc});
    if (blk_left != 0) blk_left--;
    if (part_left != 0) part_left--;
    last = (blk_left == 0);
    if (last) begin
      stage = PH_TYPE;
    end else begin
      stage = (part_left == 0) ? PH_DELTA : PH_QUOT;
      run   = '0;
    end
    acc   = '0;
    nbits = 0;
    pending_results.push_back(make_result({32{u[0]}} ^ (u >> 1), LEN_W'(1), last, ST_OK));
  endtask

  task automatic decode_bit(input logic b);
    logic [1:0]       t;
    logic [LEN_W-1:0] len;
    if (stage == PH_DELTA || stage == PH_QUOT) begin
      if (!b) begin
        if (run != '1) run++;
      end else if (stage == PH_DELTA) begin
        kparam    = apply_delta(kparam, run);
        part_left = part_length();
        stage     = PH_QUOT;
        run       = '0;
      end else begin
        acc   = '0;
        nbits = 0;
        if (rem_width() == 0) close_sample();
        else stage = PH_REM;
      end
      return;
    end
    acc = {acc[30:0], b};
    nbits++;
    case (stage)
      PH_REM: begin
        if (nbits >= rem_width()) close_sample();
      end
      PH_ORDER: begin
        if (nbits >= ORDER_FIELD_BITS) begin
          len   = eff_len(blk_reg);
          stage = PH_TYPE;
          if (acc > order_limit(len)) begin
            pending_results.push_back(make_result('0, LEN_W'(1), 1'b1, ST_BAD_ORDER));
          end else begin
            order_q  = acc[3:0];
            blk_left = len;
            stage    = PH_PARAM;
          end
          acc   = '0;
          nbits = 0;
        end
      end
      PH_PARAM: begin
        if (nbits >= PARAM_FIELD_BITS) begin
          kparam    = (acc > 31) ? 5'd31 : acc[4:0];
          part_left = part_length();
          acc       = '0;
          nbits     = 0;
          stage     = PH_QUOT;
          run       = '0;
        end
      end
      default: begin
        if (nbits >= 2) begin
          t     = acc[1:0];
          acc   = '0;
          nbits = 0;
          if (t == KIND_ALLZERO) begin
            pending_results.push_back(make_result('0, eff_len(blk_reg), 1'b1, ST_OK));
          end else if (t == KIND_INVALID) begin
            pending_results.push_back(make_result('0, LEN_W'(1), 1'b1, ST_BAD_TYPE));
          end else begin
            kind  = t;
            stage = PH_ORDER;
          end
        end
      end
    endcase
  endtask

  task automatic check_result();
    res_t got;
    res_t want;
    got.sample_value  = out_tdata[31:0];
    got.repeat_count  = out_tdata[44:32];
    got.last_in_block = out_tlast;
    got.status        = out_tuser;
    if (pending_results.size() == 0) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("unexpected result: value %0d repeat %0d last %0b status %0d",
                 got.sample_value, got.repeat_count, got.last_in_block, got.status);
    end else begin
      want = pending_results.pop_front();
      if (got !== want) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("mismatch: expected value %0d repeat %0d last %0b status %0d",
                   want.sample_value, want.repeat_count, want.last_in_block, want.status);
          $display("          got value %0d repeat %0d last %0b status %0d",
                   got.sample_value, got.repeat_count, got.last_in_block, got.status);
        end
      end
    end
  endtask

  // every transaction is mirrored at the edge that accepts it
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) blk_reg = cfg_data;
      if (in_tvalid && in_tready) decode_bit(in_tdata[0]);
      if (out_tvalid && out_tready) check_result();
    end
  end

  // ---------------------------------------------------------------- stimulus

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_bit(input logic b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {7'd0, b};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    bits_sent++;
  endtask

  task automatic send_field(input logic [31:0] v, input int width);
    for (int i = width - 1; i >= 0; i--) send_bit(v[i]);
  endtask

  task automatic send_header(input logic [1:0] code, input int order, input logic [4:0] k0,
                             output logic body);
    body = 1'b0;
    send_bit(code[1]);
    send_bit(code[0]);
    if (code == KIND_ALLZERO || code == KIND_INVALID) return;
    send_field(order, ORDER_FIELD_BITS);
    if (order > order_limit(gen_len)) return;
    send_field(k0, PARAM_FIELD_BITS);
    body = 1'b1;
  endtask

  task automatic send_sample(input logic [1:0] code, input logic [4:0] k, input int q,
                             input logic [31:0] rem);
    int n;
    n = int'(k) + ((code == KIND_RECURSIVE && q == 0) ? 1 : 0);
    repeat (q) send_bit(1'b0);
    send_bit(1'b1);
    for (int i = n - 1; i >= 0; i--) send_bit(rem[i]);
  endtask

  task automatic send_delta(input int zeros);
    repeat (zeros) send_bit(1'b0);
    send_bit(1'b1);
  endtask

  // hold the input until every expected result has left
  task automatic drain_results();
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_len(input logic [LEN_W-1:0] v);
    drain_results();
    cfg_data  = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    gen_len   = eff_len(v);
  endtask

  function automatic int rand_quotient();
    int p;
    p = $urandom_range(99);
    if (p < 70) return $urandom_range(2);
    if (p < 95) return $urandom_range(3, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic [4:0] rand_param();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 5'($urandom_range(4));
    if (p < 90) return 5'($urandom_range(5, 15));
    return 5'($urandom_range(16, 31));
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    case ($urandom_range(15))
      0:       return '0;
      1:       return LEN_W'(MAX_BLOCK_SAMPLES);
      2:       return LEN_W'($urandom_range(17, 8191));
      default: return LEN_W'($urandom_range(1, 16));
    endcase
  endfunction

  // well-formed block with random content
  task automatic emit_block(input logic [1:0] code, input int order, input logic [4:0] k0);
    logic       body;
    logic [4:0] k;
    int         left;
    int         plen;
    int         zeros;
    send_header(code, order, k0, body);
    if (!body) return;
    k    = k0;
    left = gen_len;
    plen = gen_len >> order;
    if (plen == 0) plen = 1;
    while (left > 0) begin
      for (int i = 0; i < plen && left > 0; i++) begin
        send_sample(code, k, rand_quotient(), $urandom());
        left--;
      end
      if (left > 0) begin
        zeros = ($urandom_range(99) < 80) ? $urandom_range(3) : $urandom_range(4, 70);
        send_delta(zeros);
        k = apply_delta(k, zeros);
      end
    end
  endtask

  task automatic emit_random_block();
    int   pick;
    logic body;
    pick = $urandom_range(99);
    if (pick < 6) begin
      send_header(KIND_ALLZERO, 0, 0, body);
    end else if (pick < 11) begin
      send_header(KIND_INVALID, 0, 0, body);
    end else if (pick < 18 || gen_len > 16) begin
      // long blocks only get cheap headers
      send_header(pick[0] ? KIND_RICE : KIND_RECURSIVE,
                  $urandom_range(order_limit(gen_len) + 1, 1023), 0, body);
    end else begin
      emit_block(pick[0] ? KIND_RICE : KIND_RECURSIVE,
                 $urandom_range(order_limit(gen_len)), rand_param());
    end
  endtask

  // feed ones until the decoder waits for a fresh code type
  task automatic resync();
    while (!(stage == PH_TYPE && nbits == 0)) send_bit(1'b1);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_block_codes();
    logic body;
    write_len(LEN_W'(MAX_BLOCK_SAMPLES));
    send_header(KIND_ALLZERO, 0, 0, body);
    send_header(KIND_INVALID, 0, 0, body);
    send_header(KIND_RICE, 11, 0, body);
    send_header(KIND_RECURSIVE, 1023, 0, body);
  endtask

  task automatic test_short_blocks();
    logic body;
    write_len('0);
    send_header(KIND_RICE, 0, 0, body);
    send_sample(KIND_RICE, 0, 0, '0);
    send_header(KIND_RICE, 1, 0, body);
    write_len('1);
    send_header(KIND_ALLZERO, 0, 0, body);
    write_len(1);
    send_header(KIND_ALLZERO, 0, 0, body);
    write_len(12);
    emit_block(KIND_RECURSIVE, 2, 3);
    send_header(KIND_RICE, 3, 0, body);
  endtask

  task automatic test_param_extremes();
    logic body;
    write_len(4);
    send_header(KIND_RICE, 2, 31, body);
    send_sample(KIND_RICE, 31, 2, '1);       // wraps modulo 2^32
    send_delta(4);                           // held at the top
    send_sample(KIND_RICE, 31, 0, '0);
    send_delta(63);                          // held at the bottom
    send_sample(KIND_RICE, 0, 5, '0);
    send_delta(1);
    send_sample(KIND_RICE, 0, 0, '0);
    send_header(KIND_RECURSIVE, 0, 31, body);
    send_sample(KIND_RECURSIVE, 31, 0, 32'hFFFF_FFFF);
    send_sample(KIND_RECURSIVE, 31, 0, 32'hFFFF_FFFE);
    send_sample(KIND_RECURSIVE, 31, 1, $urandom());
    send_sample(KIND_RECURSIVE, 31, 3, $urandom());
    write_len(2);
    send_header(KIND_RECURSIVE, 1, 0, body);
    send_sample(KIND_RECURSIVE, 0, 0, 1);
    send_delta(2);
    send_sample(KIND_RECURSIVE, 1, 2, 1);
  endtask

  // shorten the register inside a block: partitions shrink, block length holds
  task automatic test_midblock_length();
    logic body;
    write_len(8);
    send_header(KIND_RICE, 2, 1, body);
    send_sample(KIND_RICE, 1, 0, 1);
    send_sample(KIND_RICE, 1, 1, 0);
    write_len(1);
    repeat (6) begin
      send_delta(0);
      send_sample(KIND_RICE, 1, 2, 1);
    end
  endtask

  task automatic test_random_stream(input int target, input int s_pct, input int r_pct);
    int stop_at;
    int pick;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop_at = bits_sent + target;
    while (bits_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        write_len(rand_len());
      end else if (pick < 5) begin
        drain_results();
      end else if (pick < 13 && gen_len <= 16) begin
        repeat ($urandom_range(1, 30)) send_bit(1'($urandom_range(1)));
        resync();
      end else begin
        emit_random_block();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_block_codes();
    test_short_blocks();
    test_param_extremes();
    test_midblock_length();
    test_random_stream(700, 8, 77);
    test_random_stream(700, 77, 8);
    test_random_stream(700, 0, 0);
    drain_results();
    repeat (8) @(negedge clk);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/prd_pkg.sv
hdl/prd_ctrl.sv
hdl/prd_outreg.sv
hdl/partitioned_rice_decoder.sv
hdl/prd_checker.sv
tb/partitioned_rice_decoder_tb.sv
